@@ sv/cbc_pkg.sv @@
// ----------------------------------------------------------------------------
// cbc_pkg
// Shared types and codes for the constraint batch coloring unit.
// ----------------------------------------------------------------------------
package cbc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_PAIR,
    ST_TEST,
    ST_MARK,
    ST_FLUSH
  } cbc_state_e;

  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t REG_BATCH_LIMIT = 2'd0;
  localparam cfg_idx_t REG_BODY_COUNT  = 2'd1;

  localparam logic [3:0] BATCH_LIMIT_RST = 4'd8;
  localparam logic [7:0] BODY_COUNT_RST  = 8'd255;

endpackage

@@ sv/constraint_batch_coloring_unit.sv @@
// ----------------------------------------------------------------------------
// constraint_batch_coloring_unit
// Greedy batching of two-body constraints: no two constraints of one batch but the
// last share a body. Constraints load one per transaction; the final one starts
// a run that emits every constraint index with its batch number.
//
// Channel   Direction  Handshake                     Payload
// command   in         start & !busy                 body_a_i, body_b_i, final_item_i
// result    out        result_valid_o (one cycle)    constraint_index_o, batch_number_o,
//                                                    batch_end_o, run_end_o
// config    in         cfg_we_i                      cfg_idx_i, cfg_data_i
//
// A load transaction stores one constraint unless the list is full. A run clears
// the busy map for every stage but the last, then scans the list: an already placed
// constraint is skipped, any other has its pair read and tested and, if placed, both
// bodies marked busy; the last stage places all the rest untested. A flush ends the run.
// The final result shows in the same cycle that busy falls. The registered pair store
// read and the shared busy map write port shape these steps. Results cannot
// be stalled. Reset empties the list; each load clears its placed flag.
// ----------------------------------------------------------------------------
module constraint_batch_coloring_unit #(
  parameter int unsigned MAX_CONSTRAINTS = 64,
  parameter int unsigned MAX_BODIES      = 255,
  parameter int unsigned MAX_BATCHES     = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [7:0]        body_a_i,
  input  logic [7:0]        body_b_i,
  input  logic              final_item_i,
  input  logic              cfg_we_i,
  input  cbc_pkg::cfg_idx_t cfg_idx_i,
  input  logic [7:0]        cfg_data_i,
  output logic              result_valid_o,
  output logic [5:0]        constraint_index_o,
  output logic [2:0]        batch_number_o,
  output logic              batch_end_o,
  output logic              run_end_o
);
  import cbc_pkg::*;

  localparam int unsigned CW      = $clog2(MAX_CONSTRAINTS);
  localparam int unsigned TopCapI = (MAX_BODIES > 255) ? 255 : MAX_BODIES;
  localparam int unsigned BW      = $clog2(TopCapI + 1);
  localparam int unsigned SW      = $clog2(MAX_BATCHES + 1);
  localparam logic [7:0]  TopCap  = 8'(TopCapI);
  localparam logic [CW:0] MaxCnt  = (CW + 1)'(MAX_CONSTRAINTS);

  cbc_state_e state_q, state_d;

  logic [3:0]    batch_limit_q;
  logic [7:0]    body_count_q;
  logic [CW:0]   load_cnt_q, load_cnt_d;
  logic [CW:0]   idx_q, idx_d;
  logic [SW-1:0] stage_q, stage_d;
  logic [SW-1:0] stages_q, stages_d;
  logic [BW-1:0] top_q, top_d;
  logic [BW-1:0] clr_q, clr_d;
  logic          pend_v_q, pend_v_d;
  logic [CW-1:0] pend_idx_q, pend_idx_d;
  logic [SW-1:0] pend_stage_q, pend_stage_d;
  logic [BW-1:0] x_q, y_q;
  logic          res_v_q, res_v_d;
  logic [5:0]    res_idx_q, res_idx_d;
  logic [2:0]    res_batch_q, res_batch_d;
  logic          res_bend_q, res_bend_d;
  logic          res_rend_q, res_rend_d;

  logic [15:0]   pair_mem [MAX_CONSTRAINTS];
  logic [15:0]   pair_rd_q;
  logic          busy_mem [TopCapI + 1];
  logic          bx_q, by_q;
  logic          placed_mem [MAX_CONSTRAINTS];
  logic          placed_rd_q;

  logic          accept;
  logic          last_stage;
  logic          place;
  logic          scan_done;
  logic [BW-1:0] x_c, y_c;
  logic          bm_we;
  logic [BW-1:0] bm_addr;
  logic          bm_wdata;
  logic          pm_we;
  logic [CW-1:0] pm_addr;
  logic          pm_wdata;
  logic [7:0]    top8;
  logic [7:0]    top_sat;
  logic [SW-1:0] stages_c;

  assign busy       = (state_q != ST_IDLE);
  assign accept     = start && !busy;
  assign last_stage = (stage_q == stages_q - SW'(1));
  assign place      = last_stage || (!bx_q && !by_q);
  assign scan_done  = (idx_q == load_cnt_q);
  assign top8       = 8'(top_q);
  assign x_c        = (pair_rd_q[15:8] > top8) ? top_q : BW'(pair_rd_q[15:8]);
  assign y_c        = (pair_rd_q[7:0]  > top8) ? top_q : BW'(pair_rd_q[7:0]);
  assign top_sat    = (body_count_q > TopCap) ? TopCap : body_count_q;

  always_comb begin
    if (batch_limit_q == 4'd0) begin
      stages_c = SW'(1);
    end else if (32'(batch_limit_q) > MAX_BATCHES) begin
      stages_c = SW'(MAX_BATCHES);
    end else begin
      stages_c = SW'(batch_limit_q);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && final_item_i) begin
          state_d = (stages_c == SW'(1)) ? ST_SCAN : ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (clr_q == top_q) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          if (last_stage) begin
            state_d = ST_FLUSH;
          end else if (stage_q + SW'(1) == stages_q - SW'(1)) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_CLEAR;
          end
        end else if (!placed_rd_q) begin
          state_d = ST_PAIR;
        end
      end
      ST_PAIR: state_d = ST_TEST;
      ST_TEST: begin
        state_d = (place && !last_stage) ? ST_MARK : ST_SCAN;
      end
      ST_MARK:  state_d = ST_SCAN;
      ST_FLUSH: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    load_cnt_d   = load_cnt_q;
    idx_d        = idx_q;
    stage_d      = stage_q;
    stages_d     = stages_q;
    top_d        = top_q;
    clr_d        = clr_q;
    pend_v_d     = pend_v_q;
    pend_idx_d   = pend_idx_q;
    pend_stage_d = pend_stage_q;
    res_v_d      = 1'b0;
    res_idx_d    = res_idx_q;
    res_batch_d  = res_batch_q;
    res_bend_d   = res_bend_q;
    res_rend_d   = res_rend_q;
    bm_we        = 1'b0;
    bm_addr      = clr_q;
    bm_wdata     = 1'b0;
    pm_we        = 1'b0;
    pm_addr      = load_cnt_q[CW-1:0];
    pm_wdata     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (load_cnt_q < MaxCnt) begin
            load_cnt_d = load_cnt_q + (CW + 1)'(1);
            pm_we      = 1'b1;
            pm_addr    = load_cnt_q[CW-1:0];
            pm_wdata   = 1'b0;
          end
          if (final_item_i) begin
            idx_d    = '0;
            stage_d  = '0;
            stages_d = stages_c;
            top_d    = BW'(top_sat);
            clr_d    = '0;
            pend_v_d = 1'b0;
          end
        end
      end
      ST_CLEAR: begin
        bm_we   = 1'b1;
        bm_addr = clr_q;
        clr_d   = clr_q + BW'(1);
        if (clr_q == top_q) begin
          clr_d = '0;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          if (!last_stage) begin
            stage_d = stage_q + SW'(1);
            idx_d   = '0;
          end
        end else if (placed_rd_q) begin
          idx_d = idx_q + (CW + 1)'(1);
        end
      end
      ST_TEST: begin
        if (place) begin
          pm_we    = 1'b1;
          pm_addr  = idx_q[CW-1:0];
          pm_wdata = 1'b1;
          if (pend_v_q) begin
            res_v_d     = 1'b1;
            res_idx_d   = 6'(pend_idx_q);
            res_batch_d = 3'(pend_stage_q);
            res_bend_d  = (pend_stage_q != stage_q);
            res_rend_d  = 1'b0;
          end
          pend_v_d     = 1'b1;
          pend_idx_d   = idx_q[CW-1:0];
          pend_stage_d = stage_q;
          if (!last_stage) begin
            bm_we    = 1'b1;
            bm_addr  = x_q;
            bm_wdata = 1'b1;
          end else begin
            idx_d = idx_q + (CW + 1)'(1);
          end
        end else begin
          idx_d = idx_q + (CW + 1)'(1);
        end
      end
      ST_MARK: begin
        bm_we    = 1'b1;
        bm_addr  = y_q;
        bm_wdata = 1'b1;
        idx_d    = idx_q + (CW + 1)'(1);
      end
      ST_FLUSH: begin
        res_v_d     = pend_v_q;
        res_idx_d   = 6'(pend_idx_q);
        res_batch_d = 3'(pend_stage_q);
        res_bend_d  = 1'b1;
        res_rend_d  = 1'b1;
        pend_v_d    = 1'b0;
        load_cnt_d  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      batch_limit_q <= BATCH_LIMIT_RST;
      body_count_q  <= BODY_COUNT_RST;
      load_cnt_q    <= '0;
      idx_q         <= '0;
      stage_q       <= '0;
      stages_q      <= SW'(1);
      top_q         <= '0;
      clr_q         <= '0;
      pend_v_q      <= 1'b0;
      res_v_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      idx_q      <= idx_d;
      stage_q    <= stage_d;
      stages_q   <= stages_d;
      top_q      <= top_d;
      clr_q      <= clr_d;
      pend_v_q   <= pend_v_d;
      res_v_q    <= res_v_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_BATCH_LIMIT: batch_limit_q <= cfg_data_i[3:0];
          REG_BODY_COUNT:  body_count_q  <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q   <= pend_idx_d;
    pend_stage_q <= pend_stage_d;
    res_idx_q    <= res_idx_d;
    res_batch_q  <= res_batch_d;
    res_bend_q   <= res_bend_d;
    res_rend_q   <= res_rend_d;
    if (state_q == ST_PAIR) begin
      x_q <= x_c;
      y_q <= y_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (load_cnt_q < MaxCnt)) begin
      pair_mem[load_cnt_q[CW-1:0]] <= {body_a_i, body_b_i};
    end
    pair_rd_q <= pair_mem[idx_q[CW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (pm_we) begin
      placed_mem[pm_addr] <= pm_wdata;
    end
    if (pm_we && (pm_addr == idx_d[CW-1:0])) begin
      placed_rd_q <= pm_wdata;
    end else begin
      placed_rd_q <= placed_mem[idx_d[CW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (bm_we) begin
      busy_mem[bm_addr] <= bm_wdata;
    end
    bx_q <= busy_mem[x_c];
    by_q <= busy_mem[y_c];
  end

  assign result_valid_o     = res_v_q;
  assign constraint_index_o = res_idx_q;
  assign batch_number_o     = res_batch_q;
  assign batch_end_o        = res_bend_q;
  assign run_end_o          = res_rend_q;

endmodule

@@ tb/sv/tb_constraint_batch_coloring_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_constraint_batch_coloring_unit
// Self-checking bench for the constraint batch coloring unit. Constraint
// lists are loaded through the command port. A bench-side greedy batcher
// predicts every placement of each run. A checker compares each result
// strobe, field by field, against the oldest predicted placement. Directed
// lists cover conflicts, body id saturation, the batch limit range, spare
// register indexes and list overflow. Random runs follow, with random
// register settings and sender gaps.
// ----------------------------------------------------------------------------
module tb_constraint_batch_coloring_unit;
  import cbc_pkg::*;

  localparam int unsigned LIST_DEPTH  = 64;
  localparam int unsigned STAGE_MAX   = 8;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned ITEM_TARGET = 170;
  localparam cfg_idx_t    REG_SPARE_2 = 2'd2;
  localparam cfg_idx_t    REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [5:0] index;
    logic [2:0] batch;
    logic       batch_end;
    logic       run_end;
  } placement_t;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       start        = 1'b0;
  logic       busy;
  logic [7:0] body_a_i     = 8'd0;
  logic [7:0] body_b_i     = 8'd0;
  logic       final_item_i = 1'b0;
  logic       cfg_we_i     = 1'b0;
  cfg_idx_t   cfg_idx_i    = REG_BATCH_LIMIT;
  logic [7:0] cfg_data_i   = 8'd0;
  logic       result_valid_o;
  logic [5:0] constraint_index_o;
  logic [2:0] batch_number_o;
  logic       batch_end_o;
  logic       run_end_o;

  constraint_batch_coloring_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .body_a_i           (body_a_i),
    .body_b_i           (body_b_i),
    .final_item_i       (final_item_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .result_valid_o     (result_valid_o),
    .constraint_index_o (constraint_index_o),
    .batch_number_o     (batch_number_o),
    .batch_end_o        (batch_end_o),
    .run_end_o          (run_end_o)
  );

  placement_t  expected_placements[$];
  logic [7:0]  pair_a [LIST_DEPTH];
  logic [7:0]  pair_b [LIST_DEPTH];
  int unsigned pairs_loaded    = 0;
  logic [3:0]  batch_limit_reg = BATCH_LIMIT_RST;
  logic [7:0]  body_count_reg  = BODY_COUNT_RST;
  int unsigned errors          = 0;
  int unsigned items_sent      = 0;
  int unsigned idle_pct        = 36;
  int unsigned cycles          = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < 40) begin
      $display("ERROR at %0t: %s got %0d want %0d", $realtime, what, got, want);
    end
    errors++;
  endtask

  // Greedy batching of the loaded list; queue one placement per constraint.
  function automatic void color_batches();
    placement_t  run_q[$];
    placement_t  p;
    bit          placed [LIST_DEPTH];
    bit          body_taken [256];
    logic [7:0]  top;
    logic [7:0]  x;
    logic [7:0]  y;
    int unsigned stages;
    int unsigned first;
    top    = body_count_reg;
    stages = (batch_limit_reg == 4'd0) ? 1 :
             (batch_limit_reg > STAGE_MAX) ? STAGE_MAX : int'(batch_limit_reg);
    foreach (placed[i]) placed[i] = 1'b0;
    for (int unsigned stage = 0; stage < stages; stage++) begin
      foreach (body_taken[j]) body_taken[j] = 1'b0;
      first = run_q.size();
      for (int unsigned i = 0; i < pairs_loaded; i++) begin
        if (placed[i]) continue;
        x = (pair_a[i] > top) ? top : pair_a[i];
        y = (pair_b[i] > top) ? top : pair_b[i];
        if (stage != stages - 1) begin
          if (body_taken[x] || body_taken[y]) continue;
          body_taken[x] = 1'b1;
          body_taken[y] = 1'b1;
        end
        placed[i]   = 1'b1;
        p.index     = i[5:0];
        p.batch     = stage[2:0];
        p.batch_end = 1'b0;
        p.run_end   = 1'b0;
        run_q.push_back(p);
      end
      if (run_q.size() > first) run_q[run_q.size() - 1].batch_end = 1'b1;
    end
    if (run_q.size() > 0) run_q[run_q.size() - 1].run_end = 1'b1;
    foreach (run_q[k]) expected_placements.push_back(run_q[k]);
    pairs_loaded = 0;
  endfunction

  function automatic void load_constraint(input logic [7:0] a, input logic [7:0] b,
                                          input logic fin);
    if (pairs_loaded < LIST_DEPTH) begin
      pair_a[pairs_loaded] = a;
      pair_b[pairs_loaded] = b;
      pairs_loaded++;
    end
    items_sent++;
    if (fin) color_batches();
  endfunction

  always @(posedge clk_i) begin
    placement_t got;
    placement_t want;
    if (rst_ni && result_valid_o) begin
      got = '{constraint_index_o, batch_number_o, batch_end_o, run_end_o};
      if (expected_placements.size() == 0) begin
        report_mismatch("unexpected result, index", int'(got.index), -1);
      end else begin
        want = expected_placements.pop_front();
        if (got.index !== want.index)
          report_mismatch("constraint_index", int'(got.index), int'(want.index));
        if (got.batch !== want.batch)
          report_mismatch("batch_number", int'(got.batch), int'(want.batch));
        if (got.batch_end !== want.batch_end)
          report_mismatch("batch_end", int'(got.batch_end), int'(want.batch_end));
        if (got.run_end !== want.run_end)
          report_mismatch("run_end", int'(got.run_end), int'(want.run_end));
      end
    end
  end

  // Drop start for a random gap; scramble the payload while it is low.
  task automatic maybe_idle();
    if ($urandom_range(99) < idle_pct) begin
      start        <= 1'b0;
      body_a_i     <= 8'($urandom_range(255));
      body_b_i     <= 8'($urandom_range(255));
      final_item_i <= 1'($urandom_range(1));
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
  endtask

  task automatic send_constraint(input logic [7:0] a, input logic [7:0] b, input logic fin);
    start        <= 1'b1;
    body_a_i     <= a;
    body_b_i     <= b;
    final_item_i <= fin;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    load_constraint(a, b, fin);
    maybe_idle();
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_placements.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_BATCH_LIMIT) batch_limit_reg = data[3:0];
    else if (idx == REG_BODY_COUNT) body_count_reg = data;
    @(posedge clk_i);
  endtask

  task automatic test_reset_defaults();
    send_constraint(8'd0, 8'd255, 1'b0);
    send_constraint(8'd255, 8'd1, 1'b0);
    send_constraint(8'd0, 8'd1, 1'b0);
    send_constraint(8'd2, 8'd3, 1'b0);
    send_constraint(8'd0, 8'd255, 1'b1);
    drain();
  endtask

  task automatic test_saturation();
    write_reg(REG_BODY_COUNT, 8'd3);
    send_constraint(8'd255, 8'd4, 1'b0);
    send_constraint(8'd3, 8'd0, 1'b0);
    send_constraint(8'd200, 8'd1, 1'b0);
    send_constraint(8'd2, 8'd2, 1'b1);
    drain();
    // every id collapses onto body 0: one constraint per batch but the last
    write_reg(REG_BODY_COUNT, 8'd0);
    for (int i = 0; i < 8; i++) begin
      send_constraint(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0);
    end
    send_constraint(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b1);
    drain();
    write_reg(REG_BODY_COUNT, 8'd255);
  endtask

  task automatic test_batch_limits();
    logic [7:0] limits [3] = '{8'h00, 8'hFF, 8'hF2};
    foreach (limits[n]) begin
      write_reg(REG_BATCH_LIMIT, limits[n]);
      send_constraint(8'd5, 8'd5, 1'b0);
      send_constraint(8'd5, 8'd6, 1'b0);
      send_constraint(8'd6, 8'd5, 1'b1);
      drain();
    end
  endtask

  task automatic test_spare_registers();
    write_reg(REG_SPARE_2, 8'h01);
    write_reg(REG_SPARE_3, 8'h00);
    send_constraint(8'd9, 8'd9, 1'b1);
    drain();
  endtask

  task automatic test_full_list();
    write_reg(REG_BATCH_LIMIT, 8'd8);
    write_reg(REG_BODY_COUNT, 8'd15);
    idle_pct = 0;
    for (int i = 0; i < 69; i++) begin
      send_constraint(8'($urandom_range(15)), 8'($urandom_range(15)), 1'b0);
    end
    send_constraint(8'($urandom_range(15)), 8'($urandom_range(15)), 1'b1);
    drain();
    idle_pct = 36;
  endtask

  task automatic test_random_runs();
    int unsigned len;
    int unsigned span;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(2) == 0) begin
        drain();
        write_reg(REG_BATCH_LIMIT, 8'($urandom_range(255)));
        case ($urandom_range(2))
          0:       write_reg(REG_BODY_COUNT, 8'($urandom_range(7)));
          1:       write_reg(REG_BODY_COUNT, 8'($urandom_range(63)));
          default: write_reg(REG_BODY_COUNT, 8'($urandom_range(255)));
        endcase
        if ($urandom_range(5) == 0) write_reg(REG_SPARE_3, 8'($urandom_range(255)));
      end
      case ($urandom_range(3))
        0:       span = 3;
        1:       span = 15;
        2:       span = 63;
        default: span = 255;
      endcase
      len = $urandom_range(24, 1);
      for (int unsigned i = 1; i < len; i++) begin
        send_constraint(8'($urandom_range(span)), 8'($urandom_range(span)), 1'b0);
      end
      send_constraint(8'($urandom_range(span)), 8'($urandom_range(span)), 1'b1);
      if ($urandom_range(3) == 0) drain();
    end
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_saturation();
    test_batch_limits();
    test_spare_registers();
    test_full_list();
    test_random_runs();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
